/* design/accumulator_cpu_execute_core_assert.svh */
// Assertion macros used by the accumulator core checker.
`ifndef ACCUMULATOR_CPU_EXECUTE_CORE_ASSERT_SVH
`define ACCUMULATOR_CPU_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ACE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("accumulator core check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ACE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("accumulator core check failed");

`endif

/* design/ace_pkg.sv */
// Shared types, codes and helpers of the accumulator execute core.
package ace_pkg;

  localparam int unsigned DataDepthDef = 256;
  localparam int unsigned CodeDepthDef = 256;

  typedef enum logic [3:0] {
    OP_NOOP      = 4'h0,
    OP_ARITH_IMM = 4'h1,
    OP_ARITH_MEM = 4'h2,
    OP_CLAC      = 4'h3,
    OP_STORE     = 4'h4,
    OP_BEQZ      = 4'h5,
    OP_HALT      = 4'hF
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_INVALID = 2'd2,
    ST_STOPPED = 2'd3
  } status_e;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] instruction;
    logic [7:0]  preload_address;
    logic [7:0]  preload_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]        next_pc;
    status_e           status;
    logic signed [7:0] accumulator_out;
    logic              carry_out;
    logic              overflow_out;
    logic              zero_out;
  } out_beat_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  // a mod depth for depth in 16..256: four restoring compare/subtract steps
  function automatic logic [7:0] wrap_addr(logic [7:0] a, logic [8:0] depth);
    logic [11:0] rem;
    logic [11:0] step;
    rem = {4'd0, a};
    for (int i = 3; i >= 0; i--) begin
      step = {3'd0, depth} << i;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[7:0];
  endfunction

endpackage

/* design/ace_dmem.sv */
// Data memory: synchronous RAM, per-entry valid bits, write-to-read forwarding.
module ace_dmem
  import ace_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DataDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(DATA_DEPTH)-1:0] rd_addr_i,
  input  mem_wr_t                       wr_i,
  output logic [7:0]                    rd_data_o
);

  localparam int unsigned AW = $clog2(DATA_DEPTH);

  logic [7:0]            mem_q [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] vld_q;
  logic [7:0]            rd_raw_q;
  logic [AW-1:0]         rd_addr_q;
  mem_wr_t               last_q;
  logic [AW-1:0]         wr_addr;
  logic                  fwd_hit;

  assign wr_addr = wr_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_raw_q  <= mem_q[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // valid bits stand in for a clearing pass; last write kept for forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      last_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_addr] <= 1'b1;
      last_q         <= wr_i;
    end
  end

  assign fwd_hit   = last_q.en && (last_q.addr[AW-1:0] == rd_addr_q);
  assign rd_data_o = fwd_hit ? last_q.data : (vld_q[rd_addr_q] ? rd_raw_q : 8'd0);

endmodule

/* design/ace_exec.sv */
// Execute stage: accumulator, flags, pc, stop state, ALU and result build.
module ace_exec
  import ace_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DataDepthDef,
  parameter int unsigned CODE_DEPTH = CodeDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_beat_t  item_i,
  input  logic [7:0] operand_i,
  output out_beat_t result_o,
  output mem_wr_t   wr_o
);

  logic [7:0] acc_q, acc_d;
  logic [7:0] pc_q, pc_d;
  logic       carry_q, carry_d;
  logic       ovf_q, ovf_d;
  logic       zero_q, zero_d;
  logic       stop_q, stop_d;

  opcode_e    op;
  logic       sub;
  logic [7:0] field;
  logic [7:0] alu_b;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] alu_r;
  logic       alu_c;
  logic       alu_v;
  logic [8:0] pc_inc;
  status_e    status;
  mem_wr_t    wr;

  assign op    = opcode_e'(item_i.instruction[15:12]);
  assign sub   = (item_i.instruction[11:8] != 4'd0);
  assign field = item_i.instruction[7:0];
  assign alu_b = (op == OP_ARITH_IMM) ? field : operand_i;
  assign sum   = {1'b0, acc_q} + {1'b0, alu_b};
  assign diff  = {1'b0, acc_q} - {1'b0, alu_b};
  assign alu_r = sub ? diff[7:0] : sum[7:0];
  assign alu_c = sub ? diff[8] : sum[8];
  assign alu_v = sub ? ((acc_q[7] != alu_b[7]) && (alu_r[7] != acc_q[7]))
                     : ((acc_q[7] == alu_b[7]) && (alu_r[7] != acc_q[7]));
  assign pc_inc = {1'b0, pc_q} + 9'd1;

  always_comb begin
    acc_d   = acc_q;
    pc_d    = pc_q;
    carry_d = carry_q;
    ovf_d   = ovf_q;
    zero_d  = zero_q;
    stop_d  = stop_q;
    status  = ST_OK;
    wr      = '0;
    if (stop_q) begin
      status = ST_STOPPED;
    end else if (item_i.item_kind) begin
      wr.en   = 1'b1;
      wr.addr = wrap_addr(item_i.preload_address, 9'(DATA_DEPTH));
      wr.data = item_i.preload_value;
    end else begin
      pc_d = (pc_inc == 9'(CODE_DEPTH)) ? 8'd0 : pc_inc[7:0];
      case (op)
        OP_NOOP: begin
        end
        OP_ARITH_IMM, OP_ARITH_MEM: begin
          acc_d   = alu_r;
          carry_d = alu_c;
          ovf_d   = alu_v;
        end
        OP_CLAC: begin
          acc_d  = 8'd0;
          zero_d = 1'b1;
        end
        OP_STORE: begin
          wr.en   = 1'b1;
          wr.addr = wrap_addr(field, 9'(DATA_DEPTH));
          wr.data = acc_q;
        end
        OP_BEQZ: begin
          if (acc_q == 8'd0) begin
            pc_d = wrap_addr(field, 9'(CODE_DEPTH));
          end
        end
        OP_HALT: begin
          stop_d = 1'b1;
          status = ST_HALT;
        end
        default: begin
          stop_d = 1'b1;
          status = ST_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      pc_q    <= '0;
      carry_q <= 1'b0;
      ovf_q   <= 1'b0;
      zero_q  <= 1'b0;
      stop_q  <= 1'b0;
    end else if (fire_i) begin
      acc_q   <= acc_d;
      pc_q    <= pc_d;
      carry_q <= carry_d;
      ovf_q   <= ovf_d;
      zero_q  <= zero_d;
      stop_q  <= stop_d;
    end
  end

  always_comb begin
    wr_o                     = wr;
    wr_o.en                  = wr.en && fire_i;
    result_o.next_pc         = pc_d;
    result_o.status          = status;
    result_o.accumulator_out = acc_d;
    result_o.carry_out       = carry_d;
    result_o.overflow_out    = ovf_d;
    result_o.zero_out        = zero_d;
  end

endmodule

/* design/accumulator_cpu_execute_core.sv */
// An accepted input beat is registered in stage 1, then its result in the output register.
// Throughput: one beat per cycle while the output is not stalled; the data memory read
//   overlaps the previous beat's execute, and a same-address write is forwarded.
// Reset (async, active low) clears accumulator, flags, pc, stop state and pipeline;
//   data memory reads as zero until written (per-entry valid bits, no clear pass).
// Once HALT or a bad opcode executes, every later beat reports stopped.
module accumulator_cpu_execute_core
  import ace_pkg::*;
#(
  parameter int unsigned DATA_DEPTH = DataDepthDef,
  parameter int unsigned CODE_DEPTH = CodeDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned AW = $clog2(DATA_DEPTH);

  // stage 1 holds the beat whose memory read is in flight
  in_beat_t  s1_q;
  logic      s1_vld_q, s1_vld_d;
  out_beat_t out_q;
  logic      out_vld_q, out_vld_d;

  logic          s1_go;
  logic          fire;
  logic          in_acc;
  logic [7:0]    rd_wrap;
  logic [AW-1:0] rd_addr;
  logic [7:0]    operand;
  out_beat_t     result;
  mem_wr_t       wr;

  // execute when the output register is free or being drained this cycle
  assign s1_go      = !out_vld_q || !out_stall_i;
  assign fire       = s1_vld_q && s1_go;
  assign in_stall_o = s1_vld_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  // memory operand address issued at accept, whatever the beat kind
  assign rd_wrap = wrap_addr(in_beat_i.instruction[7:0], 9'(DATA_DEPTH));
  assign rd_addr = rd_wrap[AW-1:0];

  ace_dmem #(
    .DATA_DEPTH(DATA_DEPTH)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (operand)
  );

  ace_exec #(
    .DATA_DEPTH(DATA_DEPTH),
    .CODE_DEPTH(CODE_DEPTH)
  ) u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (s1_q),
    .operand_i (operand),
    .result_o  (result),
    .wr_o      (wr)
  );

  assign s1_vld_d  = in_acc || (s1_vld_q && !fire);
  assign out_vld_d = fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_beat_i;
    end
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

endmodule

/* design/ace_checker.sv */
// Port-level checker for the accumulator execute core, with its bind.
`include "accumulator_cpu_execute_core_assert.svh"

module ace_checker
  import ace_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  logic       out_acc;
  logic       stop_seen_q;
  logic       zero_seen_q;
  logic [7:0] last_pc_q;
  logic [7:0] last_acc_q;
  logic       frozen_ok;

  assign out_acc   = out_valid_o && !out_stall_i;
  assign frozen_ok = (out_beat_o.next_pc == last_pc_q) &&
                     (out_beat_o.accumulator_out == last_acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_seen_q <= 1'b0;
      zero_seen_q <= 1'b0;
      last_pc_q   <= '0;
      last_acc_q  <= '0;
    end else begin
      if (out_acc) begin
        last_pc_q  <= out_beat_o.next_pc;
        last_acc_q <= out_beat_o.accumulator_out;
        if (out_beat_o.status != ST_OK) begin
          stop_seen_q <= 1'b1;
        end
        if (out_beat_o.zero_out) begin
          zero_seen_q <= 1'b1;
        end
      end
    end
  end

  `ACE_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_beat_o))
  `ACE_ASSERT_IMP(a_stop_sticky, out_valid_o && stop_seen_q, out_beat_o.status == ST_STOPPED)
  `ACE_ASSERT_IMP(a_stop_frozen, out_valid_o && stop_seen_q, frozen_ok)
  `ACE_ASSERT_IMP(a_zero_sticky, out_valid_o && zero_seen_q, out_beat_o.zero_out)
  `ACE_ASSERT_IMP(a_no_idle_stall, !out_valid_o, !in_stall_o)

endmodule

bind accumulator_cpu_execute_core ace_checker u_ace_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the accumulator CPU execute core.
`timescale 1ns / 100ps

// Beats are driven on the falling edge and sampled on the rising edge.
// Every accepted input beat runs through a local model of the machine, and
// the predicted result beat is queued. Each result beat is then compared,
// field by field, with the oldest prediction.
// HALT and bad opcodes stop the core until reset. Reset happens only once, so
// the beat that stops the core comes last, followed by a few beats that the
// core must report as stopped.
module tb;
  import ace_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned QuietTail  = 150;   // last beats go with no idling

  typedef struct {
    in_beat_t beat;
    bit       drain;   // hold this beat until no result is outstanding
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  pending_t  program_queue[$];
  out_beat_t predicted_results[$];

  // machine state as the model sees it
  logic [7:0] acc_q;
  logic [7:0] pc_q;
  logic       carry_q;
  logic       ovf_q;
  logic       zero_q;
  logic       halted_q;
  logic [7:0] dmem_q [256];

  int unsigned total_beats;
  int unsigned accepted_beats;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned in_gap;
  int unsigned out_gap;
  bit          in_taken;
  bit          in_calm;
  bit          out_calm;

  accumulator_cpu_execute_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Machine model: one input beat in, one result beat out.
  // ---------------------------------------------------------------------------
  task automatic execute_beat(input in_beat_t b, output out_beat_t r);
    logic [3:0] op;
    logic       subtract;
    logic [7:0] fld;
    logic [7:0] opnd;
    logic [8:0] sum;
    status_e    st;
    op       = b.instruction[15:12];
    subtract = (b.instruction[11:8] != 4'd0);
    fld      = b.instruction[7:0];
    st       = ST_OK;
    if (halted_q) begin
      st = ST_STOPPED;
    end else if (b.item_kind) begin
      dmem_q[b.preload_address] = b.preload_value;
    end else begin
      // pc steps first, for every opcode; 8-bit wrap matches the code depth
      pc_q = pc_q + 8'd1;
      case (op)
        OP_NOOP: begin
        end
        OP_ARITH_IMM, OP_ARITH_MEM: begin
          opnd = (op == OP_ARITH_IMM) ? fld : dmem_q[fld];
          if (subtract) begin
            sum     = {1'b0, acc_q} - {1'b0, opnd};
            carry_q = (acc_q < opnd);   // borrow
            ovf_q   = (acc_q[7] != opnd[7]) && (sum[7] != acc_q[7]);
          end else begin
            sum     = {1'b0, acc_q} + {1'b0, opnd};
            carry_q = sum[8];
            ovf_q   = (acc_q[7] == opnd[7]) && (sum[7] != acc_q[7]);
          end
          acc_q = sum[7:0];
        end
        OP_CLAC: begin
          acc_q  = 8'd0;
          zero_q = 1'b1;   // the only writer of the zero flag
        end
        OP_STORE: begin
          dmem_q[fld] = acc_q;
        end
        OP_BEQZ: begin
          if (acc_q == 8'd0) begin
            pc_q = fld;
          end
        end
        OP_HALT: begin
          halted_q = 1'b1;
          st       = ST_HALT;
        end
        default: begin
          halted_q = 1'b1;
          st       = ST_INVALID;
        end
      endcase
    end
    r.next_pc         = pc_q;
    r.status          = st;
    r.accumulator_out = acc_q;
    r.carry_out       = carry_q;
    r.overflow_out    = ovf_q;
    r.zero_out        = zero_q;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Beat builders. Fields the core ignores still get random values.
  // ---------------------------------------------------------------------------
  function automatic in_beat_t instr_beat(input logic [3:0] op, input logic [3:0] sel,
                                          input logic [7:0] fld);
    in_beat_t b;
    b.item_kind       = 1'b0;
    b.instruction     = {op, sel, fld};
    b.preload_address = 8'($urandom);
    b.preload_value   = 8'($urandom);
    return b;
  endfunction

  function automatic in_beat_t preload_beat(input logic [7:0] addr, input logic [7:0] val);
    in_beat_t b;
    b.item_kind       = 1'b1;
    b.instruction     = 16'($urandom);
    b.preload_address = addr;
    b.preload_value   = val;
    return b;
  endfunction

  task automatic push_beat(input in_beat_t b, input bit drain = 1'b0);
    pending_t p;
    p.beat  = b;
    p.drain = drain;
    program_queue.push_back(p);
  endtask

  // mostly a small window of addresses so stores and reads collide often
  function automatic logic [7:0] pick_addr();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
  endfunction

  function automatic logic [3:0] pick_sel();
    return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: next pending beat once the current one is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic     nv;
    in_beat_t nb;
    bit       quiet;
    nv    = in_valid_i;
    nb    = in_beat_i;
    quiet = (program_queue.size() < QuietTail);
    if (rst_ni && (!in_valid_i || in_taken)) begin
      nv = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (program_queue.size() > 0 &&
                   !(program_queue[0].drain && predicted_results.size() > 0)) begin
        nb = program_queue.pop_front().beat;
        nv = 1'b1;
        if (!quiet && !in_calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 8);
        end
      end
    end
    in_valid_i <= nv;
    in_beat_i  <= nb;
  end

  // Output back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (program_queue.size() >= QuietTail && !out_calm && $urandom_range(0, 6) == 0) begin
      out_gap = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted input beat, check each result beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_beat_t want;
    out_beat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_beat_o;
      if (predicted_results.size() == 0) begin
        $display("%0t: result beat with none expected, actual %0h", $time, got);
        fail_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("next_pc", want.next_pc, got.next_pc);
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("accumulator_out", want.accumulator_out, got.accumulator_out);
        check_field("carry_out", 8'(want.carry_out), 8'(got.carry_out));
        check_field("overflow_out", 8'(want.overflow_out), 8'(got.overflow_out));
        check_field("zero_out", 8'(want.zero_out), 8'(got.zero_out));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      execute_beat(in_beat_i, want);
      predicted_results.push_back(want);
      accepted_beats++;
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Cycle limit, plus periodic switching into stretches with no idling.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count % 100 == 0) begin
      in_calm  <= ($urandom_range(0, 3) == 0);
      out_calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] a;
    int unsigned pick;
    acc_q    = '0;
    pc_q     = '0;
    carry_q  = 1'b0;
    ovf_q    = 1'b0;
    zero_q   = 1'b0;
    halted_q = 1'b0;
    for (int i = 0; i < 256; i++) begin
      dmem_q[i] = 8'd0;
    end

    // directed: operand extremes, both carries, both overflows, pc wrap,
    // BEQZ taken and not, store followed at once by a read of the same byte
    push_beat(preload_beat(8'h00, 8'h7F));
    push_beat(preload_beat(8'hFF, 8'h80));
    push_beat(preload_beat(8'h10, 8'hFF));
    push_beat(instr_beat(OP_ARITH_MEM, 4'h0, 8'h00));   // 0x7F
    push_beat(instr_beat(OP_ARITH_IMM, 4'h0, 8'h01));   // 0x80, signed overflow
    push_beat(instr_beat(OP_ARITH_IMM, 4'h0, 8'hFF));   // carry and overflow
    push_beat(instr_beat(OP_ARITH_MEM, 4'h1, 8'hFF));   // borrow, overflow
    push_beat(instr_beat(OP_NOOP, 4'hF, 8'hFF));
    push_beat(instr_beat(OP_BEQZ, 4'h0, 8'h40));        // not taken
    push_beat(instr_beat(OP_CLAC, 4'hA, 8'h55));
    push_beat(instr_beat(OP_BEQZ, 4'h0, 8'hFF));        // taken to the top
    push_beat(instr_beat(OP_NOOP, 4'h0, 8'h00));        // pc wraps to zero
    push_beat(instr_beat(OP_STORE, 4'h0, 8'hFF));
    push_beat(instr_beat(OP_ARITH_MEM, 4'h0, 8'hFF));
    push_beat(instr_beat(OP_ARITH_IMM, 4'h8, 8'h00));   // 0 - 0, no borrow
    push_beat(instr_beat(OP_ARITH_IMM, 4'hF, 8'h01));   // 0 - 1, borrow
    push_beat(instr_beat(OP_ARITH_MEM, 4'h0, 8'h10));   // 0xFF + 0xFF
    push_beat(instr_beat(OP_STORE, 4'h0, 8'h00));
    push_beat(instr_beat(OP_ARITH_MEM, 4'h2, 8'h00));   // reads the byte just stored
    push_beat(preload_beat(8'h20, 8'h81));
    push_beat(instr_beat(OP_ARITH_MEM, 4'h0, 8'h20));   // reads the byte just preloaded
    push_beat(instr_beat(OP_ARITH_IMM, 4'h0, 8'h00));

    // random program; the sender waits for a full drain once in the middle
    for (int n = 0; n < 1180; n++) begin
      pick = $urandom_range(0, 99);
      a    = pick_addr();
      if (pick < 14) begin
        push_beat(preload_beat(a, 8'($urandom)), n == 600);
      end else if (pick < 22) begin
        push_beat(instr_beat(OP_NOOP, 4'($urandom), 8'($urandom)), n == 600);
      end else if (pick < 40) begin
        push_beat(instr_beat(OP_ARITH_IMM, pick_sel(), 8'($urandom)), n == 600);
      end else if (pick < 60) begin
        push_beat(instr_beat(OP_ARITH_MEM, pick_sel(), a), n == 600);
      end else if (pick < 68) begin
        push_beat(instr_beat(OP_CLAC, 4'($urandom), 8'($urandom)), n == 600);
      end else if (pick < 82) begin
        push_beat(instr_beat(OP_STORE, 4'($urandom), a), n == 600);
        if ($urandom_range(0, 1) == 0) begin
          push_beat(instr_beat(OP_ARITH_MEM, pick_sel(), a));
        end
      end else begin
        push_beat(instr_beat(OP_BEQZ, 4'($urandom), 8'($urandom)), n == 600);
      end
    end

    // the stopping beat, then beats the core must ignore
    if ($urandom_range(0, 1) == 0) begin
      push_beat(instr_beat(OP_HALT, 4'($urandom), 8'($urandom)));
    end else begin
      push_beat(instr_beat(4'($urandom_range(6, 14)), 4'($urandom), 8'($urandom)));
    end
    for (int n = 0; n < 12; n++) begin
      if ($urandom_range(0, 2) == 0) begin
        push_beat(preload_beat(8'($urandom), 8'($urandom)));
      end else begin
        push_beat(instr_beat(4'($urandom), 4'($urandom), 8'($urandom)));
      end
    end
    total_beats = program_queue.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_beats < total_beats) @(posedge clk_i);
    while (predicted_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
